### hdl/dpfc_pkg.sv
// ----------------------------------------------------------------------------
// dpfc_pkg: shared types and constants
// Page states, result action codes, register indexes and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package dpfc_pkg;

    // Default sizing
    localparam int DEF_MAX_PAGES  = 4096;
    localparam int DEF_MAX_FRAMES = 512;

    // Fixed field widths
    localparam int PAGE_W    = 12;
    localparam int FRAME_W   = 9;
    localparam int ACT_W     = 3;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 3;
    localparam int LIM_W     = 5;

    // Register reset values
    localparam int PAGE_COUNT_RST  = 4096;
    localparam int POOL_RST        = 512;
    localparam int EVICT_LIM_RST   = 31;
    localparam int READ_AHEAD_RST  = 31;
    localparam int FETCH_DIRTY_RST = 1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_COUNT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_FRAMES = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EVICT_LIM   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_AHEAD  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FETCH_DIRTY = 3'd4;

    // Per-page state codes
    localparam logic [1:0] PS_UNMAPPED = 2'd0;
    localparam logic [1:0] PS_CLEAN    = 2'd1;
    localparam logic [1:0] PS_DIRTY    = 2'd2;

    // Result actions
    localparam logic [ACT_W-1:0] ACT_NONE  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_EVICT = 3'd1;
    localparam logic [ACT_W-1:0] ACT_FETCH = 3'd2;
    localparam logic [ACT_W-1:0] ACT_DIRTY = 3'd3;
    localparam logic [ACT_W-1:0] ACT_RANGE = 3'd4;

    typedef enum logic [2:0] {
        PTR_HOLD,
        PTR_ZERO,
        PTR_INC,
        PTR_FAULT,
        PTR_NEXT
    } t_ptr_op;

    typedef enum logic [1:0] {
        FRM_ZERO,
        FRM_PAGE,
        FRM_QUEUE
    } t_frm_sel;

    typedef struct packed {
        logic             load_fault;
        t_ptr_op          ptr_op;
        logic             cnt_clr;
        logic             cnt_inc;
        logic             mark_dirty;
        logic             evict;
        logic             map;
        logic             emit;
        logic [ACT_W-1:0] emit_action;
        logic             emit_fault;
        t_frm_sel         emit_frame;
        logic             emit_wb;
        logic             finish;
    } t_cmd;

    typedef struct packed {
        logic       clear_busy;
        logic       out_of_range;
        logic [1:0] rd_state;
        logic       free_empty;
        logic       can_emit;
        logic       out_free;
        logic       scan_end;
        logic       evict_full;
        logic       ra_none;
        logic       ra_end;
    } t_sts;

endpackage

### hdl/dpfc_ctrl.sv
// ----------------------------------------------------------------------------
// dpfc_ctrl: fault sequencer
// Decodes the page state, walks the eviction scan and the read-ahead walk,
// and tells the datapath when to write tables, move the frame queue and emit.
// ----------------------------------------------------------------------------
module dpfc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  dpfc_pkg::t_sts i_sts,
    output dpfc_pkg::t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_WAIT_DEC,
        S_DEC,
        S_EV_WAIT,
        S_EV,
        S_POP_WAIT,
        S_FETCH,
        S_RA_WAIT,
        S_RA,
        S_FIN
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and commands
    always_comb begin
        n_state            = r_state;
        o_cmd              = '0;
        o_cmd.ptr_op       = dpfc_pkg::PTR_HOLD;
        o_cmd.emit_frame   = dpfc_pkg::FRM_ZERO;
        o_cmd.emit_action  = dpfc_pkg::ACT_NONE;
        o_in_stall         = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = i_sts.clear_busy;
                if (i_in_valid && !i_sts.clear_busy) begin
                    o_cmd.load_fault = 1'b1;
                    n_state          = S_WAIT_DEC;
                end
            end
            S_WAIT_DEC: begin
                n_state = S_DEC;
            end
            S_DEC: begin
                if (i_sts.out_of_range) begin
                    if (i_sts.can_emit) begin
                        o_cmd.emit        = 1'b1;
                        o_cmd.emit_action = dpfc_pkg::ACT_RANGE;
                        o_cmd.emit_fault  = 1'b1;
                        n_state           = S_FIN;
                    end
                end else if (i_sts.rd_state == dpfc_pkg::PS_UNMAPPED) begin
                    if (i_sts.free_empty) begin
                        o_cmd.ptr_op  = dpfc_pkg::PTR_ZERO;
                        o_cmd.cnt_clr = 1'b1;
                        n_state       = S_EV_WAIT;
                    end else begin
                        n_state = S_POP_WAIT;
                    end
                end else if (i_sts.rd_state == dpfc_pkg::PS_CLEAN) begin
                    if (i_sts.can_emit) begin
                        o_cmd.mark_dirty  = 1'b1;
                        o_cmd.emit        = 1'b1;
                        o_cmd.emit_action = dpfc_pkg::ACT_DIRTY;
                        o_cmd.emit_fault  = 1'b1;
                        n_state           = S_FIN;
                    end
                end else begin
                    if (i_sts.can_emit) begin
                        o_cmd.emit        = 1'b1;
                        o_cmd.emit_action = dpfc_pkg::ACT_NONE;
                        o_cmd.emit_fault  = 1'b1;
                        n_state           = S_FIN;
                    end
                end
            end
            S_EV_WAIT: begin
                n_state = S_EV;
            end
            // Eviction scan over S_EV_WAIT and S_EV; it waits at a mapped page while no result can be emitted
            S_EV: begin
                if (i_sts.rd_state != dpfc_pkg::PS_UNMAPPED) begin
                    if (i_sts.can_emit) begin
                        o_cmd.evict       = 1'b1;
                        o_cmd.emit        = 1'b1;
                        o_cmd.emit_action = dpfc_pkg::ACT_EVICT;
                        o_cmd.emit_frame  = dpfc_pkg::FRM_PAGE;
                        o_cmd.emit_wb     = (i_sts.rd_state == dpfc_pkg::PS_DIRTY);
                        o_cmd.cnt_inc     = 1'b1;
                        if (i_sts.scan_end || i_sts.evict_full) begin
                            o_cmd.ptr_op = dpfc_pkg::PTR_FAULT;
                            n_state      = S_POP_WAIT;
                        end else begin
                            o_cmd.ptr_op = dpfc_pkg::PTR_INC;
                            n_state      = S_EV_WAIT;
                        end
                    end
                end else if (i_sts.scan_end) begin
                    o_cmd.ptr_op = dpfc_pkg::PTR_FAULT;
                    n_state      = S_POP_WAIT;
                end else begin
                    o_cmd.ptr_op = dpfc_pkg::PTR_INC;
                    n_state      = S_EV_WAIT;
                end
            end
            S_POP_WAIT: begin
                n_state = S_FETCH;
            end
            // Map the faulting page, or report no action when no frame is free
            S_FETCH: begin
                if (i_sts.can_emit) begin
                    o_cmd.emit       = 1'b1;
                    o_cmd.emit_fault = 1'b1;
                    if (i_sts.free_empty) begin
                        o_cmd.emit_action = dpfc_pkg::ACT_NONE;
                        n_state           = S_FIN;
                    end else begin
                        o_cmd.map         = 1'b1;
                        o_cmd.emit_action = dpfc_pkg::ACT_FETCH;
                        o_cmd.emit_frame  = dpfc_pkg::FRM_QUEUE;
                        o_cmd.cnt_clr     = 1'b1;
                        if (i_sts.ra_none) begin
                            n_state = S_FIN;
                        end else begin
                            o_cmd.ptr_op = dpfc_pkg::PTR_NEXT;
                            n_state      = S_RA_WAIT;
                        end
                    end
                end
            end
            S_RA_WAIT: begin
                n_state = S_RA;
            end
            // Read-ahead walk
            S_RA: begin
                if (i_sts.rd_state != dpfc_pkg::PS_UNMAPPED) begin
                    o_cmd.cnt_inc = 1'b1;
                    if (i_sts.ra_end) begin
                        n_state = S_FIN;
                    end else begin
                        o_cmd.ptr_op = dpfc_pkg::PTR_NEXT;
                        n_state      = S_RA_WAIT;
                    end
                end else if (i_sts.free_empty) begin
                    n_state = S_FIN;
                end else if (i_sts.can_emit) begin
                    o_cmd.map         = 1'b1;
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_action = dpfc_pkg::ACT_FETCH;
                    o_cmd.emit_frame  = dpfc_pkg::FRM_QUEUE;
                    o_cmd.cnt_inc     = 1'b1;
                    if (i_sts.ra_end) begin
                        n_state = S_FIN;
                    end else begin
                        o_cmd.ptr_op = dpfc_pkg::PTR_NEXT;
                        n_state      = S_RA_WAIT;
                    end
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### hdl/dpfc_dp.sv
// ----------------------------------------------------------------------------
// dpfc_dp: paging datapath
// Configuration registers, page state and frame tables, the free-frame
// queue, the clearing pass, and the pending and output result registers.
// ----------------------------------------------------------------------------
module dpfc_dp #(
    parameter int MAX_PAGES  = dpfc_pkg::DEF_MAX_PAGES,
    parameter int MAX_FRAMES = dpfc_pkg::DEF_MAX_FRAMES
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [dpfc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [dpfc_pkg::CFG_W-1:0]       i_cfg_wdata,
    input  logic [dpfc_pkg::PAGE_W-1:0]      i_fault_page,
    input  logic                             i_out_stall,
    input  dpfc_pkg::t_cmd                   i_cmd,
    output dpfc_pkg::t_sts                   o_sts,
    output logic                             o_out_valid,
    output logic [dpfc_pkg::ACT_W-1:0]       o_action,
    output logic [dpfc_pkg::PAGE_W-1:0]      o_page_index,
    output logic [dpfc_pkg::FRAME_W-1:0]     o_frame_index,
    output logic                             o_write_back,
    output logic                             o_last
);

    localparam int PW      = $clog2(MAX_PAGES);
    localparam int FW      = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CNTW    = $clog2(MAX_FRAMES + 1);
    localparam int CLR_LEN = (MAX_PAGES > MAX_FRAMES) ? MAX_PAGES : MAX_FRAMES;
    localparam int CLW     = $clog2(CLR_LEN);
    localparam int XW      = ((PW > dpfc_pkg::CFG_W) ? PW : dpfc_pkg::CFG_W) + 1;
    localparam int PC_RST  = (dpfc_pkg::PAGE_COUNT_RST > MAX_PAGES) ?
                             MAX_PAGES : dpfc_pkg::PAGE_COUNT_RST;
    localparam int POOL_RST = (dpfc_pkg::POOL_RST > MAX_FRAMES) ?
                              MAX_FRAMES : dpfc_pkg::POOL_RST;
    localparam int TAIL_RST = (POOL_RST == MAX_FRAMES) ? 0 : POOL_RST;

    // Configuration
    logic [dpfc_pkg::CFG_W-1:0] r_page_count;
    logic [dpfc_pkg::LIM_W-1:0] r_evict_lim;
    logic [dpfc_pkg::LIM_W-1:0] r_ra_count;
    logic                       r_fetch_dirty;

    // Working registers
    logic [dpfc_pkg::PAGE_W-1:0] r_fault;
    logic [PW-1:0]               r_ptr;
    logic [dpfc_pkg::LIM_W-1:0]  r_cnt;
    logic [FW-1:0]               r_head;
    logic [FW-1:0]               r_tail;
    logic [CNTW-1:0]             r_free;
    logic                        r_clr_busy;
    logic [CLW-1:0]              r_clr;

    // Memories and their read registers
    logic [1:0]    ps_mem [MAX_PAGES];
    logic [FW-1:0] pf_mem [MAX_PAGES];
    logic [FW-1:0] q_mem  [MAX_FRAMES];
    logic [1:0]    r_rd_state;
    logic [FW-1:0] r_rd_frame;
    logic [FW-1:0] r_rd_q;

    // Pending and output results
    logic                         r_pend_v;
    logic [dpfc_pkg::ACT_W-1:0]   r_pend_action;
    logic [dpfc_pkg::PAGE_W-1:0]  r_pend_page;
    logic [dpfc_pkg::FRAME_W-1:0] r_pend_frame;
    logic                         r_pend_wb;
    logic                         r_out_v;
    logic [dpfc_pkg::ACT_W-1:0]   r_out_action;
    logic [dpfc_pkg::PAGE_W-1:0]  r_out_page;
    logic [dpfc_pkg::FRAME_W-1:0] r_out_frame;
    logic                         r_out_wb;
    logic                         r_out_last;

    logic                         out_free;
    logic                         free_full;
    logic [1:0]                   map_state;
    logic [PW-1:0]                ptr_next;
    logic [dpfc_pkg::CFG_W-1:0]   pc_val;
    logic [9:0]                   pool_raw;
    logic [CNTW-1:0]              pool_val;
    logic [dpfc_pkg::PAGE_W-1:0]  new_page;
    logic [dpfc_pkg::FRAME_W-1:0] new_frame;

    assign out_free  = !r_out_v || !i_out_stall;
    assign free_full = (r_free == CNTW'(MAX_FRAMES));
    assign map_state = r_fetch_dirty ? dpfc_pkg::PS_DIRTY : dpfc_pkg::PS_CLEAN;

    // Read-ahead step wraps at the page count
    always_comb begin
        if ((XW'(r_ptr) + XW'(1)) < XW'(r_page_count)) begin
            ptr_next = r_ptr + PW'(1);
        end else begin
            ptr_next = '0;
        end
    end

    // Register value clamping
    always_comb begin
        pc_val   = i_cfg_wdata;
        pool_raw = i_cfg_wdata[9:0];
        pool_val = CNTW'(MAX_FRAMES);
        if (pc_val == '0) begin
            pc_val = dpfc_pkg::CFG_W'(1);
        end else if (int'(pc_val) > MAX_PAGES) begin
            pc_val = dpfc_pkg::CFG_W'(MAX_PAGES);
        end
        if (pool_raw == '0) begin
            pool_val = CNTW'(1);
        end else if (int'(pool_raw) <= MAX_FRAMES) begin
            pool_val = CNTW'(pool_raw);
        end
    end

    // Result fields of a new emit
    always_comb begin
        new_page = i_cmd.emit_fault ? r_fault : dpfc_pkg::PAGE_W'(r_ptr);
        case (i_cmd.emit_frame)
            dpfc_pkg::FRM_PAGE:  new_frame = dpfc_pkg::FRAME_W'(r_rd_frame);
            dpfc_pkg::FRM_QUEUE: new_frame = dpfc_pkg::FRAME_W'(r_rd_q);
            default:             new_frame = '0;
        endcase
    end

    // Configuration, pointers, queue control and clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_count  <= dpfc_pkg::CFG_W'(PC_RST);
            r_evict_lim   <= dpfc_pkg::LIM_W'(dpfc_pkg::EVICT_LIM_RST);
            r_ra_count    <= dpfc_pkg::LIM_W'(dpfc_pkg::READ_AHEAD_RST);
            r_fetch_dirty <= 1'(dpfc_pkg::FETCH_DIRTY_RST);
            r_head        <= '0;
            r_tail        <= FW'(TAIL_RST);
            r_free        <= CNTW'(POOL_RST);
            r_clr_busy    <= 1'b1;
            r_clr         <= '0;
            r_cnt         <= '0;
        end else begin
            if (r_clr_busy) begin
                r_clr <= r_clr + CLW'(1);
                if (r_clr == CLW'(CLR_LEN - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (i_cmd.cnt_clr) begin
                r_cnt <= '0;
            end else if (i_cmd.cnt_inc) begin
                r_cnt <= r_cnt + dpfc_pkg::LIM_W'(1);
            end
            // Frame queue: evict pushes, map pops
            if (i_cmd.evict && !free_full) begin
                r_tail <= (r_tail == FW'(MAX_FRAMES - 1)) ? '0 : r_tail + FW'(1);
                r_free <= r_free + CNTW'(1);
            end else if (i_cmd.map) begin
                r_head <= (r_head == FW'(MAX_FRAMES - 1)) ? '0 : r_head + FW'(1);
                r_free <= r_free - CNTW'(1);
            end
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    dpfc_pkg::CFG_PAGE_COUNT: begin
                        r_page_count <= pc_val;
                    end
                    dpfc_pkg::CFG_POOL_FRAMES: begin
                        r_free     <= pool_val;
                        r_head     <= '0;
                        r_tail     <= (pool_val == CNTW'(MAX_FRAMES)) ? '0 : FW'(pool_val);
                        r_clr_busy <= 1'b1;
                        r_clr      <= '0;
                    end
                    dpfc_pkg::CFG_EVICT_LIM: begin
                        r_evict_lim <= (i_cfg_wdata[4:0] == '0) ?
                                       dpfc_pkg::LIM_W'(1) : i_cfg_wdata[4:0];
                    end
                    dpfc_pkg::CFG_READ_AHEAD: begin
                        r_ra_count <= i_cfg_wdata[4:0];
                    end
                    dpfc_pkg::CFG_FETCH_DIRTY: begin
                        r_fetch_dirty <= i_cfg_wdata[0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Fault page and table pointer
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_fault) begin
            r_fault <= i_fault_page;
            r_ptr   <= PW'(i_fault_page);
        end else begin
            case (i_cmd.ptr_op)
                dpfc_pkg::PTR_ZERO:  r_ptr <= '0;
                dpfc_pkg::PTR_INC:   r_ptr <= r_ptr + PW'(1);
                dpfc_pkg::PTR_FAULT: r_ptr <= PW'(r_fault);
                dpfc_pkg::PTR_NEXT:  r_ptr <= ptr_next;
                default:             r_ptr <= r_ptr;
            endcase
        end
    end

    // Page state table
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            if (int'(r_clr) < MAX_PAGES) begin
                ps_mem[PW'(r_clr)] <= dpfc_pkg::PS_UNMAPPED;
            end
        end else if (i_cmd.mark_dirty) begin
            ps_mem[r_ptr] <= dpfc_pkg::PS_DIRTY;
        end else if (i_cmd.evict) begin
            ps_mem[r_ptr] <= dpfc_pkg::PS_UNMAPPED;
        end else if (i_cmd.map) begin
            ps_mem[r_ptr] <= map_state;
        end
        r_rd_state <= ps_mem[r_ptr];
    end

    // Page-to-frame table
    always_ff @(posedge i_clk) begin
        if (i_cmd.map) begin
            pf_mem[r_ptr] <= r_rd_q;
        end
        r_rd_frame <= pf_mem[r_ptr];
    end

    // Free-frame queue
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            if (int'(r_clr) < MAX_FRAMES) begin
                q_mem[FW'(r_clr)] <= FW'(r_clr);
            end
        end else if (i_cmd.evict && !free_full) begin
            q_mem[r_tail] <= r_rd_frame;
        end
        r_rd_q <= q_mem[r_head];
    end

    // Pending result and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (i_cmd.emit) begin
                r_pend_v      <= 1'b1;
                r_pend_action <= i_cmd.emit_action;
                r_pend_page   <= new_page;
                r_pend_frame  <= new_frame;
                r_pend_wb     <= i_cmd.emit_wb;
            end else if (i_cmd.finish) begin
                r_pend_v <= 1'b0;
            end
            if ((i_cmd.emit && r_pend_v) || i_cmd.finish) begin
                r_out_v      <= 1'b1;
                r_out_action <= r_pend_action;
                r_out_page   <= r_pend_page;
                r_out_frame  <= r_pend_frame;
                r_out_wb     <= r_pend_wb;
                r_out_last   <= i_cmd.finish;
            end else if (out_free) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // Status to the controller
    always_comb begin
        o_sts.clear_busy   = r_clr_busy;
        o_sts.out_of_range = ({1'b0, r_fault} >= r_page_count);
        o_sts.rd_state     = r_rd_state;
        o_sts.free_empty   = (r_free == '0);
        o_sts.can_emit     = !r_pend_v || out_free;
        o_sts.out_free     = out_free;
        o_sts.scan_end     = (r_ptr == PW'(MAX_PAGES - 1));
        o_sts.evict_full   = (({1'b0, r_cnt} + 6'd1) >= {1'b0, r_evict_lim});
        o_sts.ra_none      = (r_ra_count == '0);
        o_sts.ra_end       = (({1'b0, r_cnt} + 6'd1) == {1'b0, r_ra_count});
    end

    assign o_out_valid   = r_out_v;
    assign o_action      = r_out_action;
    assign o_page_index  = r_out_page;
    assign o_frame_index = r_out_frame;
    assign o_write_back  = r_out_wb;
    assign o_last        = r_out_last;

    // Checks
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_free) <= MAX_FRAMES)
        else $error("free frame count above pool size");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.map |-> (r_free != '0))
        else $error("frame taken from an empty queue");

    a_no_update_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !(i_cmd.map || i_cmd.evict || i_cmd.mark_dirty))
        else $error("table update during clearing pass");

    a_finish_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> r_pend_v)
        else $error("final request without a pending result");

endmodule

### hdl/demand_page_fault_controller.sv
// ----------------------------------------------------------------------------
// demand_page_fault_controller: demand-paging fault handler
// Per-page state and frame tables with a FIFO pool of free frames.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel (i_in_valid / o_in_stall) carries one fault request naming a
//  virtual page. Output channel (o_out_valid / i_out_stall) returns 1 to 63
//  result requests per fault; o_last marks the final one.
//  Config is a plain write port (i_cfg_wr_en, i_cfg_index, i_cfg_wdata), to
//  be written only while no fault is in flight; the block does not check it.
//  Eviction scan and read-ahead examine pages one at a time (the scan up to
//  MAX_PAGES pages); each page takes a wait state and a decide state, set
//  by the registered page-table read port.
//  One fault is handled at a time; the next one is taken while the final
//  result still waits in the output register.
//  Reset and every pool_frames write start a clearing pass that unmaps all
//  pages and refills the frame queue; o_in_stall stays high during it.
//  A stalled output holds its result and the sequencer waits.
// ----------------------------------------------------------------------------
module demand_page_fault_controller #(
    parameter int MAX_PAGES  = dpfc_pkg::DEF_MAX_PAGES,
    parameter int MAX_FRAMES = dpfc_pkg::DEF_MAX_FRAMES
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [dpfc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [dpfc_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [dpfc_pkg::PAGE_W-1:0]    i_fault_page,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [dpfc_pkg::ACT_W-1:0]     o_action,
    output logic [dpfc_pkg::PAGE_W-1:0]    o_page_index,
    output logic [dpfc_pkg::FRAME_W-1:0]   o_frame_index,
    output logic                           o_write_back,
    output logic                           o_last
);

    dpfc_pkg::t_cmd cmd;
    dpfc_pkg::t_sts sts;

    // Sequencer
    dpfc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Tables, queue and result registers
    dpfc_dp #(
        .MAX_PAGES  (MAX_PAGES),
        .MAX_FRAMES (MAX_FRAMES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_fault_page  (i_fault_page),
        .i_out_stall   (i_out_stall),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_out_valid   (o_out_valid),
        .o_action      (o_action),
        .o_page_index  (o_page_index),
        .o_frame_index (o_frame_index),
        .o_write_back  (o_write_back),
        .o_last        (o_last)
    );

endmodule
